// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the chunked stop-and-wait sender.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed: condition does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/csaw_pkg.sv
// Types and constants of the chunked stop-and-wait sender.
// No dependencies; imported by chunked_stop_and_wait_sender.
`default_nettype none

package csaw_pkg;

    // Control item kinds
    localparam logic [2:0] KIND_RESET    = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_ACK      = 3'd2;
    localparam logic [2:0] KIND_NACK     = 3'd3;
    localparam logic [2:0] KIND_ACK_DONE = 3'd4;

    // NACK reasons; anything else aborts the transfer
    localparam logic [1:0] NACK_SEQ_MISMATCH = 2'd0;
    localparam logic [1:0] NACK_OVERFLOW     = 2'd1;

    // Emitted packet kinds
    localparam logic [1:0] PKT_DATA       = 2'd0;
    localparam logic [1:0] PKT_END        = 2'd1;
    localparam logic [1:0] PKT_START_NACK = 2'd2;

    localparam logic [7:0] NACK_CODE_NO_SOURCE = 8'd1;

    localparam logic [5:0] MAX_PAYLOAD = 6'd56;

    // Nominal resend position (seq * 56) fits in 22 bits for any 16-bit seq
    localparam int POSITION_W = 22;
    // Quotient position / buffer size for buffers of at least 64 bytes
    localparam int QUOT_W     = 16;
    // Width of the scaled reciprocal of the buffer size
    localparam int RECIP_W    = 17;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  sub_command;
        logic [31:0] total_length;
        logic [7:0]  source_status;
        logic        source_has_data;
        logic [15:0] seq_in;
        logic [1:0]  nack_reason;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  packet_kind;
        logic [15:0] seq_out;
        logic [5:0]  payload_length;
        logic [11:0] buffer_offset;
        logic [7:0]  nack_sub_command;
        logic [7:0]  nack_code;
    } t_out_req;

endpackage

`default_nettype wire

// File: hw/rtl/chunked_stop_and_wait_sender.sv
// Chunked stop-and-wait sender: control path that turns link control items
// into packet descriptors. Depends on csaw_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries control requests:
//   reset, start, ack, nack, ack done. Output channel (o_out_valid /
//   i_out_stall / o_out) carries at most one descriptor per request: a data
//   packet, a zero-length end packet, or a start refusal.
//   The source_present register is written through i_cfg_we / i_cfg_wdata;
//   the user must write it only while no request is in flight (the block does not enforce it).
//   Throughput: one request per cycle while o_in_stall is low. Transfer state is updated in the
//   cycle a request is accepted, so a following ack may enter next cycle.
//   A descriptor is registered through stages s1 and s2 and the output register.
//   The last two stages compute the buffer offset of a stale-ack resend,
//   a reduction of seq*56 modulo the buffer size done as a registered
//   reciprocal multiply followed by a multiply, subtract and one correction.
//   Reset (i_rst_n low, synchronous) clears the transfer state, the
//   register and all pipeline valids.
//   When the receiver stalls, the output holds; requests keep entering
//   until the pipeline stages behind the output are full, then o_in_stall
//   rises in the same cycle.
`default_nettype none
`include "assert_macros.svh"

module chunked_stop_and_wait_sender #(
    parameter int unsigned CHUNK_BUFFER_BYTES = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire csaw_pkg::t_in_req i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output csaw_pkg::t_out_req  o_out
);
    import csaw_pkg::*;

    localparam int POS_W = $clog2(CHUNK_BUFFER_BYTES);
    localparam logic [POS_W:0] CBB = (POS_W+1)'(CHUNK_BUFFER_BYTES);
    localparam logic [POS_W-1:0] SAT_POS =
        POS_W'(32'hFFFF_FFFF % CHUNK_BUFFER_BYTES);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((32'd1 << POSITION_W) / CHUNK_BUFFER_BYTES);
    localparam int PROD_W = POSITION_W + RECIP_W;

    typedef struct packed {
        logic [1:0]            pkind;
        logic [15:0]           seq;
        logic [5:0]            len;
        logic [POS_W-1:0]      pos;
        logic                  resend;
        logic [POSITION_W-1:0] position;
        logic [7:0]            nsub;
        logic [7:0]            ncode;
    } t_desc;

    // transfer state
    logic                  r_src_present;
    logic [31:0]           r_total,        n_total;
    logic [31:0]           r_acked,        n_acked;
    logic [POS_W-1:0]      r_acked_pos,    n_acked_pos;
    logic [15:0]           r_expected_seq, n_expected_seq;
    logic [5:0]            r_last_len,     n_last_len;
    logic                  r_waiting,      n_waiting;

    // pipeline
    logic                  r_s1_valid, r_s2_valid, r_out_valid;
    t_desc                 r_s1, r_s2, n_desc;
    logic [QUOT_W-1:0]     r_s2_q;
    t_out_req              r_out, n_out;

    logic                  out_ready, s2_ready, s1_ready, acc;
    logic                  e_emit, do_send;

    // ack bookkeeping
    logic [32:0]           ack_sum;
    logic [31:0]           acked_add;
    logic [POS_W:0]        pos_sum, pos_wrap;
    logic [POS_W-1:0]      pos_add;

    // next-packet send
    logic [31:0]           sn_acked, sn_total, sn_rem;
    logic [POS_W-1:0]      sn_pos;
    logic [15:0]           sn_seq;
    logic                  sn_done, sn_refill_fail;
    logic [5:0]            sn_len0, sn_len;
    logic [POS_W:0]        sn_end, sn_room;

    // stale-ack resend
    logic [15:0]           rs_seq;
    logic [POSITION_W-1:0] rs_position;
    logic [31:0]           rs_rem;
    logic                  rs_hit;
    logic [5:0]            rs_len0;

    // offset reduction
    logic [PROD_W-1:0]     q_prod;
    logic [32:0]           m_prod;
    logic [POSITION_W-1:0] m_rem, m_fix;
    logic [POS_W-1:0]      rs_pos, fin_pos;
    logic [POS_W:0]        rs_end, rs_room;
    logic [5:0]            rs_len, fin_len;

    // check terms
    logic                  out_ctl, out_empty, good_start;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_stall = !s1_ready;
    assign acc        = i_in_valid && s1_ready;

    // saturating add of the last packet length, offset tracked alongside
    always_comb begin
        ack_sum  = {1'b0, r_acked} + 33'(r_last_len);
        acked_add = ack_sum[32] ? 32'hFFFF_FFFF : ack_sum[31:0];
        pos_sum  = {1'b0, r_acked_pos} + (POS_W+1)'(r_last_len);
        pos_wrap = (pos_sum >= CBB) ? (pos_sum - CBB) : pos_sum;
        pos_add  = ack_sum[32] ? SAT_POS : pos_wrap[POS_W-1:0];
    end

    // operands of the next-packet send for each request kind
    always_comb begin
        sn_acked = r_acked;
        sn_pos   = r_acked_pos;
        sn_total = r_total;
        sn_seq   = r_expected_seq;
        case (i_in.kind)
            KIND_START: begin
                sn_acked = '0;
                sn_pos   = '0;
                sn_total = i_in.total_length;
                sn_seq   = '0;
            end
            KIND_ACK: begin
                sn_acked = acked_add;
                sn_pos   = pos_add;
                sn_seq   = r_expected_seq + 16'd1;
            end
            KIND_NACK: begin
                if (i_in.nack_reason == NACK_SEQ_MISMATCH) begin
                    sn_seq = i_in.seq_in;
                end
            end
            default: begin
            end
        endcase

        sn_rem  = sn_total - sn_acked;
        sn_done = sn_acked >= sn_total;
        // a chunk boundary mid-transfer needs a refill from the source
        sn_refill_fail = (sn_pos == '0) && (sn_acked != '0) && !sn_done &&
                         ((i_in.source_status != 8'd0) || !i_in.source_has_data);
        sn_len0 = (sn_rem >= 32'(MAX_PAYLOAD)) ? MAX_PAYLOAD : sn_rem[5:0];
        sn_end  = {1'b0, sn_pos} + (POS_W+1)'(sn_len0);
        sn_room = CBB - {1'b0, sn_pos};
        sn_len  = (sn_end > CBB) ? sn_room[5:0] : sn_len0;
    end

    // resend from the nominal position (seq_in + 1) * 56
    always_comb begin
        rs_seq      = i_in.seq_in + 16'd1;
        rs_position = POSITION_W'({rs_seq, 5'b0}) + POSITION_W'({rs_seq, 4'b0}) +
                      POSITION_W'({rs_seq, 3'b0});
        rs_hit      = 32'(rs_position) < r_total;
        rs_rem      = r_total - 32'(rs_position);
        rs_len0     = (rs_rem >= 32'(MAX_PAYLOAD)) ? MAX_PAYLOAD : rs_rem[5:0];
    end

    always_comb begin
        n_total        = r_total;
        n_acked        = r_acked;
        n_acked_pos    = r_acked_pos;
        n_expected_seq = r_expected_seq;
        n_last_len     = r_last_len;
        n_waiting      = r_waiting;
        e_emit         = 1'b0;
        do_send        = 1'b0;
        n_desc         = '0;

        unique case (i_in.kind)
            KIND_RESET: begin
                n_total        = '0;
                n_acked        = '0;
                n_acked_pos    = '0;
                n_expected_seq = '0;
                n_last_len     = '0;
                n_waiting      = 1'b0;
            end
            KIND_START: begin
                if (!r_src_present ||
                    (i_in.source_status != 8'd0) || !i_in.source_has_data) begin
                    e_emit         = 1'b1;
                    n_desc.pkind   = PKT_START_NACK;
                    n_desc.nsub    = i_in.sub_command;
                    n_desc.ncode   = r_src_present ? i_in.source_status
                                                   : NACK_CODE_NO_SOURCE;
                    n_total        = '0;
                    n_acked        = '0;
                    n_acked_pos    = '0;
                    n_expected_seq = '0;
                    n_last_len     = '0;
                    n_waiting      = 1'b0;
                end else begin
                    n_total        = i_in.total_length;
                    n_acked        = '0;
                    n_acked_pos    = '0;
                    n_expected_seq = '0;
                    n_waiting      = i_in.total_length != '0;
                    do_send        = i_in.total_length != '0;
                end
            end
            KIND_ACK: begin
                if (i_in.seq_in != r_expected_seq) begin
                    // stale ack: resend the packet after it; ignore acks ahead
                    if ((i_in.seq_in < r_expected_seq) && rs_hit) begin
                        e_emit          = 1'b1;
                        n_desc.pkind    = PKT_DATA;
                        n_desc.seq      = rs_seq;
                        n_desc.len      = rs_len0;
                        n_desc.resend   = 1'b1;
                        n_desc.position = rs_position;
                    end
                end else begin
                    n_acked        = acked_add;
                    n_acked_pos    = pos_add;
                    n_expected_seq = r_expected_seq + 16'd1;
                    if (acked_add >= r_total) begin
                        n_waiting = 1'b0;
                    end else begin
                        do_send = 1'b1;
                    end
                end
            end
            KIND_NACK: begin
                if ((i_in.nack_reason == NACK_SEQ_MISMATCH) ||
                    (i_in.nack_reason == NACK_OVERFLOW)) begin
                    do_send = 1'b1;
                end else begin
                    n_total        = '0;
                    n_acked        = '0;
                    n_acked_pos    = '0;
                    n_expected_seq = '0;
                    n_last_len     = '0;
                    n_waiting      = 1'b0;
                end
            end
            KIND_ACK_DONE: begin
                n_waiting = 1'b0;
            end
            default: begin
            end
        endcase

        if (do_send && r_src_present) begin
            if (sn_refill_fail) begin
                e_emit       = 1'b1;
                n_desc.pkind = PKT_END;
                n_desc.seq   = sn_seq;
                n_waiting    = 1'b0;
            end else if (!sn_done) begin
                e_emit       = 1'b1;
                n_desc.pkind = PKT_DATA;
                n_desc.seq   = sn_seq;
                n_desc.len   = sn_len;
                n_desc.pos   = sn_pos;
                n_last_len   = sn_len;
            end
        end
    end

    // quotient estimate: floor(position * floor(2^22 / size) / 2^22),
    // at most one below the true quotient
    assign q_prod = PROD_W'(r_s1.position) * PROD_W'(RECIP);

    always_comb begin
        m_prod  = 33'(r_s2_q) * 33'(CBB);
        m_rem   = r_s2.position - m_prod[POSITION_W-1:0];
        m_fix   = (m_rem >= POSITION_W'(CBB)) ? (m_rem - POSITION_W'(CBB)) : m_rem;
        rs_pos  = m_fix[POS_W-1:0];
        rs_end  = {1'b0, rs_pos} + (POS_W+1)'(r_s2.len);
        rs_room = CBB - {1'b0, rs_pos};
        rs_len  = (rs_end > CBB) ? rs_room[5:0] : r_s2.len;

        fin_pos = r_s2.resend ? rs_pos : r_s2.pos;
        fin_len = r_s2.resend ? rs_len : r_s2.len;

        n_out.packet_kind      = r_s2.pkind;
        n_out.seq_out          = r_s2.seq;
        n_out.payload_length   = fin_len;
        n_out.buffer_offset    = 12'(fin_pos);
        n_out.nack_sub_command = r_s2.nsub;
        n_out.nack_code        = r_s2.ncode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_present  <= 1'b0;
            r_total        <= '0;
            r_acked        <= '0;
            r_acked_pos    <= '0;
            r_expected_seq <= '0;
            r_last_len     <= '0;
            r_waiting      <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_s2_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_src_present <= i_cfg_wdata;
            end
            if (acc) begin
                r_total        <= n_total;
                r_acked        <= n_acked;
                r_acked_pos    <= n_acked_pos;
                r_expected_seq <= n_expected_seq;
                r_last_len     <= n_last_len;
                r_waiting      <= n_waiting;
            end
            if (s1_ready) begin
                r_s1_valid <= acc && e_emit;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1 <= n_desc;
        end
        if (s2_ready) begin
            r_s2   <= r_s1;
            r_s2_q <= q_prod[POSITION_W +: QUOT_W];
        end
        if (out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign out_ctl    = o_out_valid && (o_out.packet_kind != PKT_DATA);
    assign out_empty  = (o_out.payload_length == 6'd0) && (o_out.buffer_offset == 12'd0);
    assign good_start = acc && (i_in.kind == KIND_START) && r_src_present &&
                        (i_in.source_status == 8'd0) && i_in.source_has_data &&
                        (i_in.total_length != 32'd0);

    // running offset always stays inside the chunk buffer
    `ASSERT_ALWAYS(a_pos_in_buffer, i_clk, i_rst_n, {1'b0, r_acked_pos} < CBB)
    // data never exceeds the payload limit; end and refusal carry none
    `ASSERT_IMPLY(a_len_limit, i_clk, i_rst_n, o_out_valid, o_out.payload_length <= MAX_PAYLOAD)
    `ASSERT_IMPLY(a_empty_ctl, i_clk, i_rst_n, out_ctl, out_empty)
    // a good start with data leaves the sender waiting for an ack
    `ASSERT_NEXT(a_start_waits, i_clk, i_rst_n, good_start, r_waiting)

endmodule

`default_nettype wire
